// ----- hw/rtl/idle_entry_victim_select_unit_macros.svh -----
`ifndef IDLE_ENTRY_VICTIM_SELECT_UNIT_MACROS_SVH
`define IDLE_ENTRY_VICTIM_SELECT_UNIT_MACROS_SVH

// same-cycle implication
`define IEVS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IEVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ievs_pkg.sv -----
package ievs_pkg;

   localparam int KIND_BITS     = 2;
   localparam int SLOT_BITS     = 6;
   localparam int OWNER_ID_BITS = 16;
   localparam int STAMP_BITS    = 32;
   localparam int CFG_BITS      = 16;
   localparam int FULL_BITS     = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int REQ_DATA_BITS = 88;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PENALTY    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_AGE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_COUNT = 2'd2;

   localparam logic [CFG_BITS-1:0]  PENALTY_RESET    = 16'd5000;
   localparam logic [CFG_BITS-1:0]  MIN_AGE_RESET    = 16'd500;
   localparam logic [FULL_BITS-1:0] FULL_COUNT_RESET = 7'd32;

   // entry update broadcast to every cell
   typedef struct packed {
      logic                 write;
      logic                 clear;
      logic [SLOT_BITS-1:0] slot;
      logic                 busy;
      logic                 played;
   } upd_type;

   // control part of the search token
   typedef struct packed {
      logic valid;
      logic have;
   } tok_type;

endpackage

// ----- hw/rtl/ievs_cell.sv -----
module ievs_cell #(
   parameter int OWNER_BITS = 16,
   parameter int TIME_BITS  = 32,
   parameter int IDX_BITS   = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ievs_pkg::upd_type     upd,
   input  logic [OWNER_BITS-1:0] wr_owner,
   input  logic [TIME_BITS-1:0]  wr_time,
   input  logic [TIME_BITS-1:0]  penalty,
   input  logic                  advance,
   input  ievs_pkg::tok_type     up_tok,
   input  logic [OWNER_BITS-1:0] up_owner,
   input  logic [TIME_BITS-1:0]  up_now,
   input  logic [TIME_BITS-1:0]  up_age,
   input  logic [IDX_BITS-1:0]   up_idx,
   output ievs_pkg::tok_type     dn_tok,
   output logic [OWNER_BITS-1:0] dn_owner,
   output logic [TIME_BITS-1:0]  dn_now,
   output logic [TIME_BITS-1:0]  dn_age,
   output logic [IDX_BITS-1:0]   dn_idx,
   output logic                  entry_valid
);
   import ievs_pkg::*;

   logic                  valid_ff, valid_in;
   logic [OWNER_BITS-1:0] owner_ff;
   logic                  busy_ff;
   logic                  played_ff;
   logic [TIME_BITS-1:0]  loaded_ff;

   tok_type               tok_ff, tok_in;
   logic [OWNER_BITS-1:0] tok_owner_ff;
   logic [TIME_BITS-1:0]  tok_now_ff;
   logic [TIME_BITS-1:0]  tok_age_ff, tok_age_in;
   logic [IDX_BITS-1:0]   tok_idx_ff, tok_idx_in;

   logic                  sel;
   logic                  hit;
   logic                  take;
   logic [TIME_BITS-1:0]  age;

   assign sel = (32'(upd.slot) == CELL_INDEX);
   assign hit = valid_ff && !busy_ff && (owner_ff == up_owner);
   assign age = up_now - loaded_ff - (played_ff ? '0 : penalty);
   assign take = up_tok.valid && hit &&
                 (!up_tok.have || ($signed(up_age) < $signed(age)));

   always_comb begin
      valid_in = valid_ff;
      if (upd.write && sel) begin
         valid_in = 1'b1;
      end else if (upd.clear && sel) begin
         valid_in = 1'b0;
      end
      tok_in     = up_tok;
      tok_age_in = up_age;
      tok_idx_in = up_idx;
      if (take) begin
         tok_in.have = 1'b1;
         tok_age_in  = age;
         tok_idx_in  = IDX_BITS'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.write && sel) begin
         owner_ff  <= wr_owner;
         busy_ff   <= upd.busy;
         played_ff <= upd.played;
         loaded_ff <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_owner_ff <= up_owner;
         tok_now_ff   <= up_now;
         tok_age_ff   <= tok_age_in;
         tok_idx_ff   <= tok_idx_in;
      end
   end

   assign dn_tok      = tok_ff;
   assign dn_owner    = tok_owner_ff;
   assign dn_now      = tok_now_ff;
   assign dn_age      = tok_age_ff;
   assign dn_idx      = tok_idx_ff;
   assign entry_valid = valid_ff;

endmodule

// ----- hw/rtl/idle_entry_victim_select_unit.sv -----
// Victim selection over a table of preloaded entries, one entry per cell.
// req channel: tuser carries the kind (write, clear, find victim), tdata the
// slot, owner, in-use and played marks, load time and current time.
// rsp channel: one transfer per find-victim request; tuser is the found flag,
// tdata the victim index (zero when nothing was found).
// csr port: csr_we writes csr_wdata into register csr_index (penalty for
// never-played entries, minimum age, full count); write only while idle.
// Write and clear requests are accepted back to back while no search is running.
// A find-victim request sends a search token down the row of cells, one cell
// per cycle unless the row is frozen (see below); req_tready stays low from the
// request transfer until the token leaves the last cell, so no new request is
// taken while a search is in the row. A waiting result does not block new
// requests; if a second result reaches the end of the row while the first is
// still held, the row freezes until rsp_tready takes the first.
// Reset clears every entry's valid bit, the valid count and the registers to
// their defaults (5000, 500, 32); no result is pending after it.
module idle_entry_victim_select_unit #(
   parameter int MAX_ENTRIES = 64,
   parameter int OWNER_BITS  = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot, owner_id, in_use, was_played, load_time, now_time
   input  logic [ievs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // kind
   input  logic [ievs_pkg::KIND_BITS-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // victim_index
   output logic [ievs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // found
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [ievs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ievs_pkg::CFG_BITS-1:0]       csr_wdata
);
   import ievs_pkg::*;

   `include "idle_entry_victim_select_unit_macros.svh"

   localparam int IDX_BITS = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

   logic [CFG_BITS-1:0]  penalty_ff, penalty_in;
   logic [CFG_BITS-1:0]  min_age_ff, min_age_in;
   logic [FULL_BITS-1:0] full_ff, full_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 scan_ff, scan_in;

   tok_type               head_ff, head_in;
   logic [OWNER_BITS-1:0] head_owner_ff;
   logic [TIME_BITS-1:0]  head_now_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [SLOT_BITS-1:0]     rsp_idx_ff, rsp_idx_in;

   tok_type               tok_ctl   [0:MAX_ENTRIES];
   logic [OWNER_BITS-1:0] tok_owner [0:MAX_ENTRIES];
   logic [TIME_BITS-1:0]  tok_now   [0:MAX_ENTRIES];
   logic [TIME_BITS-1:0]  tok_age   [0:MAX_ENTRIES];
   logic [IDX_BITS-1:0]   tok_idx   [0:MAX_ENTRIES];
   logic [MAX_ENTRIES:0]  tok_valid_vec;

   logic [MAX_ENTRIES-1:0] valid_vec;

   logic [KIND_BITS-1:0]     f_kind;
   logic [SLOT_BITS-1:0]     f_slot;
   logic [OWNER_ID_BITS-1:0] f_owner;
   logic                     f_in_use;
   logic                     f_played;
   logic [STAMP_BITS-1:0]    f_load;
   logic [STAMP_BITS-1:0]    f_now;

   logic                  req_xfer;
   logic                  advance;
   logic                  tail_exit;
   upd_type               upd;
   logic                  in_range;
   logic [IDX_BITS-1:0]   slot_idx;
   logic                  cur_valid;
   logic [OWNER_BITS-1:0] owner_w;
   logic [TIME_BITS-1:0]  load_w;
   logic [TIME_BITS-1:0]  penalty_w;
   logic                  young;
   logic                  not_full;

   assign f_kind   = req_tuser;
   assign f_slot   = req_tdata[5:0];
   assign f_owner  = req_tdata[21:6];
   assign f_in_use = req_tdata[22];
   assign f_played = req_tdata[23];
   assign f_load   = req_tdata[55:24];
   assign f_now    = req_tdata[87:56];

   assign req_tready = !scan_ff;
   assign req_xfer   = req_tvalid && req_tready;

   assign advance   = !(tok_ctl[MAX_ENTRIES].valid && rsp_valid_ff && !rsp_tready);
   assign tail_exit = tok_ctl[MAX_ENTRIES].valid && advance;

   assign owner_w   = OWNER_BITS'(f_owner);
   assign load_w    = TIME_BITS'(f_load);
   assign penalty_w = TIME_BITS'(penalty_ff);

   assign in_range  = (32'(f_slot) < MAX_ENTRIES);
   assign slot_idx  = IDX_BITS'(f_slot);
   assign cur_valid = in_range && valid_vec[slot_idx];

   always_comb begin
      upd        = '0;
      upd.slot   = f_slot;
      upd.busy   = f_in_use;
      upd.played = f_played;
      upd.write  = req_xfer && (f_kind == KIND_WRITE);
      upd.clear  = req_xfer && (f_kind == KIND_CLEAR);
   end

   assign tok_ctl[0]   = head_ff;
   assign tok_owner[0] = head_owner_ff;
   assign tok_now[0]   = head_now_ff;
   assign tok_age[0]   = '0;
   assign tok_idx[0]   = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      ievs_cell #(
         .OWNER_BITS (OWNER_BITS),
         .TIME_BITS  (TIME_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .upd         (upd),
         .wr_owner    (owner_w),
         .wr_time     (load_w),
         .penalty     (penalty_w),
         .advance     (advance),
         .up_tok      (tok_ctl[i]),
         .up_owner    (tok_owner[i]),
         .up_now      (tok_now[i]),
         .up_age      (tok_age[i]),
         .up_idx      (tok_idx[i]),
         .dn_tok      (tok_ctl[i+1]),
         .dn_owner    (tok_owner[i+1]),
         .dn_now      (tok_now[i+1]),
         .dn_age      (tok_age[i+1]),
         .dn_idx      (tok_idx[i+1]),
         .entry_valid (valid_vec[i])
      );
   end

   for (genvar i = 0; i <= MAX_ENTRIES; i++) begin : g_tokv
      assign tok_valid_vec[i] = tok_ctl[i].valid;
   end

   assign young = $signed({tok_age[MAX_ENTRIES][TIME_BITS-1], tok_age[MAX_ENTRIES]}) <
                  $signed({1'b0, TIME_BITS'(min_age_ff)});
   assign not_full = (32'(count_ff) < 32'(full_ff));

   always_comb begin
      penalty_in = penalty_ff;
      min_age_in = min_age_ff;
      full_in    = full_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PENALTY:    penalty_in = csr_wdata;
            CSR_MIN_AGE:    min_age_in = csr_wdata;
            CSR_FULL_COUNT: full_in    = FULL_BITS'(csr_wdata);
            default: ;
         endcase
      end

      count_in = count_ff;
      if (upd.write && in_range && !cur_valid) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (upd.clear && cur_valid) begin
         count_in = count_ff - CNT_BITS'(1);
      end

      head_in = head_ff;
      scan_in = scan_ff;
      if (req_xfer && (f_kind == KIND_QUERY)) begin
         head_in.valid = 1'b1;
         head_in.have  = 1'b0;
         scan_in       = 1'b1;
      end else begin
         if (advance) begin
            head_in = '0;
         end
         if (tail_exit) begin
            scan_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (tail_exit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = tok_ctl[MAX_ENTRIES].have && !(young && not_full);
         rsp_idx_in   = rsp_found_in ? SLOT_BITS'(tok_idx[MAX_ENTRIES]) : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff   <= PENALTY_RESET;
         min_age_ff   <= MIN_AGE_RESET;
         full_ff      <= FULL_COUNT_RESET;
         count_ff     <= '0;
         scan_ff      <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         penalty_ff   <= penalty_in;
         min_age_ff   <= min_age_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (f_kind == KIND_QUERY)) begin
         head_owner_ff <= owner_w;
         head_now_ff   <= TIME_BITS'(f_now);
      end
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - SLOT_BITS){1'b0}}, rsp_idx_ff};

   `IEVS_ASSERT_IMP(a_count_matches, clock, reset, 1'b1,
      $countones(valid_vec) == 32'(count_ff), "valid count out of step with valid bits")
   `IEVS_ASSERT_IMP(a_single_token, clock, reset, 1'b1,
      $countones(tok_valid_vec) <= 1, "more than one search token in the row")
   `IEVS_ASSERT_IMP(a_busy_while_scan, clock, reset, |tok_valid_vec,
      !req_tready, "request taken while a search is in the row")
   `IEVS_ASSERT_NEXT(a_exit_to_rsp, clock, reset, tail_exit,
      rsp_valid_ff, "search result lost at end of row")

endmodule

// ----- tb/idle_entry_victim_select_unit_tb.sv -----
`timescale 1ns / 1ps

module idle_entry_victim_select_unit_tb;
   import ievs_pkg::*;

   localparam int N_SLOTS      = 64;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 600;

   localparam logic [KIND_BITS-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NONE    = 2'd3;

   typedef struct packed {
      logic [STAMP_BITS-1:0]    now_time;
      logic [STAMP_BITS-1:0]    load_time;
      logic                     was_played;
      logic                     in_use;
      logic [OWNER_ID_BITS-1:0] owner_id;
      logic [SLOT_BITS-1:0]     slot;
   } req_fields_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] index;
   } victim_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic [KIND_BITS-1:0]      req_tuser  = KIND_WRITE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index  = CSR_PENALTY;
   logic [CFG_BITS-1:0]       csr_wdata  = '0;

   // table and register copy kept by the predictor
   bit                       tbl_valid  [N_SLOTS];
   logic [OWNER_ID_BITS-1:0] tbl_owner  [N_SLOTS];
   bit                       tbl_busy   [N_SLOTS];
   bit                       tbl_played [N_SLOTS];
   logic [STAMP_BITS-1:0]    tbl_loaded [N_SLOTS];
   int                       tbl_count = 0;
   logic [CFG_BITS-1:0]      cfg_penalty    = PENALTY_RESET;
   logic [CFG_BITS-1:0]      cfg_min_age    = MIN_AGE_RESET;
   logic [FULL_BITS-1:0]     cfg_full_count = FULL_COUNT_RESET;

   victim_type victim_q[$];
   victim_type seen_victim;

   int error_count = 0;
   int n_writes    = 0;
   int n_clears    = 0;
   int n_queries   = 0;
   int n_found     = 0;
   int n_settings  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   logic [OWNER_ID_BITS-1:0] owner_pool[4];
   logic [STAMP_BITS-1:0]    time_base;

   idle_entry_victim_select_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
      error_count++;
   endtask

   // update the table copy and queue the victim a query should return
   function automatic void track_request(logic [KIND_BITS-1:0] kind, req_fields_type f);
      victim_type            v;
      logic [STAMP_BITS-1:0] diff;
      logic signed [31:0]    age;
      logic signed [31:0]    best_age;
      bit                    have;
      int                    best;
      have     = 1'b0;
      best     = 0;
      best_age = '0;
      case (kind)
         KIND_WRITE: begin
            if (!tbl_valid[f.slot]) tbl_count++;
            tbl_valid[f.slot]  = 1'b1;
            tbl_owner[f.slot]  = f.owner_id;
            tbl_busy[f.slot]   = f.in_use;
            tbl_played[f.slot] = f.was_played;
            tbl_loaded[f.slot] = f.load_time;
            n_writes++;
         end
         KIND_CLEAR: begin
            if (tbl_valid[f.slot]) begin
               tbl_valid[f.slot] = 1'b0;
               tbl_count--;
            end
            n_clears++;
         end
         KIND_QUERY: begin
            for (int i = 0; i < N_SLOTS; i++) begin
               if (tbl_valid[i] && !tbl_busy[i] && tbl_owner[i] == f.owner_id) begin
                  diff = f.now_time - tbl_loaded[i];
                  if (!tbl_played[i]) diff = diff - {16'd0, cfg_penalty};
                  age = diff;
                  if (!have || best_age < age) begin
                     have     = 1'b1;
                     best_age = age;
                     best     = i;
                  end
               end
            end
            if (have && best_age < $signed({16'd0, cfg_min_age}) &&
                tbl_count < int'(cfg_full_count))
               have = 1'b0;
            v.found = have;
            v.index = have ? SLOT_BITS'(best) : '0;
            victim_q.push_back(v);
            n_queries++;
            if (have) n_found++;
         end
         default: ;
      endcase
   endfunction

   task automatic send_req(logic [KIND_BITS-1:0] kind, req_fields_type f);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_request(kind, f);
   endtask

   task automatic put_entry(logic [SLOT_BITS-1:0] slot, logic [OWNER_ID_BITS-1:0] owner,
                            logic busy, logic played, logic [STAMP_BITS-1:0] load);
      req_fields_type f;
      f            = '0;
      f.slot       = slot;
      f.owner_id   = owner;
      f.in_use     = busy;
      f.was_played = played;
      f.load_time  = load;
      send_req(KIND_WRITE, f);
   endtask

   task automatic drop_entry(logic [SLOT_BITS-1:0] slot);
      req_fields_type f;
      f      = '0;
      f.slot = slot;
      send_req(KIND_CLEAR, f);
   endtask

   task automatic ask(logic [OWNER_ID_BITS-1:0] owner, logic [STAMP_BITS-1:0] now);
      req_fields_type f;
      f          = '0;
      f.owner_id = owner;
      f.now_time = now;
      send_req(KIND_QUERY, f);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (victim_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // the unused index gets random data and must change nothing
   task automatic load_registers(logic [CFG_BITS-1:0] penalty, logic [CFG_BITS-1:0] min_age,
                                 logic [FULL_BITS-1:0] full);
      csr_cycle(CSR_PENALTY, penalty);
      csr_cycle(CSR_MIN_AGE, min_age);
      csr_cycle(CSR_FULL_COUNT, {9'd0, full});
      csr_cycle(CSR_NONE, CFG_BITS'($urandom));
      csr_we         <= 1'b0;
      cfg_penalty    = penalty;
      cfg_min_age    = min_age;
      cfg_full_count = full;
      n_settings++;
   endtask

   task automatic load_random_registers();
      load_registers(CFG_BITS'($urandom_range(0, 8000)), CFG_BITS'($urandom_range(0, 3000)),
                     FULL_BITS'($urandom_range(0, 64)));
   endtask

   task automatic random_burst(int count);
      req_fields_type        f;
      logic [95:0]           noise;
      int                    sel;
      logic [KIND_BITS-1:0]  kind;
      for (int k = 0; k < count; k++) begin
         sel       = $urandom_range(0, 99);
         noise     = {$urandom, $urandom, $urandom};
         f         = noise[REQ_DATA_BITS-1:0];
         time_base = time_base + $urandom_range(0, 400);
         // most items work on a few owners around the running time
         if ($urandom_range(0, 9) != 0) begin
            f.owner_id  = owner_pool[$urandom_range(0, 3)];
            f.in_use    = ($urandom_range(0, 3) == 0);
            f.load_time = time_base - $urandom_range(0, 9000);
            f.now_time  = time_base + $urandom_range(0, 3000);
         end
         if (sel < 40) kind = KIND_WRITE;
         else if (sel < 55) kind = KIND_CLEAR;
         else if (sel < 96) kind = KIND_QUERY;
         else kind = KIND_UNUSED;
         send_req(kind, f);
      end
   endtask

   task automatic test_directed_cases();
      req_fields_type f;
      idle_pct  = 0;
      stall_pct = 0;
      ask(16'h0000, 32'd1000);
      put_entry(6'd0, 16'h0000, 1'b0, 1'b1, 32'h0000_0000);
      put_entry(6'd63, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFF);
      ask(16'h0000, 32'd100);
      ask(16'h0000, 32'h7FFF_FFFF);
      ask(16'hFFFF, 32'h0000_2000);
      ask(16'hFFFF, 32'h0000_1000);
      put_entry(6'd5, 16'h0000, 1'b0, 1'b1, 32'h0000_0000);
      ask(16'h0000, 32'd5000);
      put_entry(6'd0, 16'h0000, 1'b1, 1'b1, 32'h0000_0000);
      ask(16'h0000, 32'd5000);
      drop_entry(6'd7);
      drop_entry(6'd5);
      ask(16'h0000, 32'd5000);
      f = REQ_DATA_BITS'({$urandom, $urandom, $urandom});
      send_req(KIND_UNUSED, f);
      put_entry(6'd10, 16'h0000, 1'b0, 1'b1, 32'h8000_0000);
      ask(16'h0000, 32'h0000_0000);
      wait_idle();
      // table counts as full, so young and negative ages qualify
      load_registers(PENALTY_RESET, MIN_AGE_RESET, 7'd2);
      ask(16'h0000, 32'h0000_0000);
      ask(16'hFFFF, 32'h0000_1000);
      wait_idle();
      load_registers(PENALTY_RESET, MIN_AGE_RESET, FULL_COUNT_RESET);
      put_entry(6'd1, 16'h0000, 1'b0, 1'b1, 32'd100);
      put_entry(6'd2, 16'h0000, 1'b0, 1'b0, 32'd100);
      ask(16'h0000, 32'd10000);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      idle_pct  = 0;
      stall_pct = 0;
      load_registers(16'd0, 16'd0, 7'd0);
      random_burst(30);
      wait_idle();
      load_registers(16'hFFFF, 16'hFFFF, 7'd64);
      random_burst(30);
      wait_idle();
      load_random_registers();
      random_burst(40);
      wait_idle();
   endtask

   task automatic test_sender_gaps();
      idle_pct  = 60;
      stall_pct = 0;
      load_random_registers();
      random_burst(90);
      wait_idle();
   endtask

   task automatic test_receiver_stalls();
      idle_pct  = 0;
      stall_pct = 60;
      load_random_registers();
      random_burst(90);
      wait_idle();
   endtask

   task automatic test_mixed_idling();
      idle_pct  = 7;
      stall_pct = 7;
      load_random_registers();
      random_burst(90);
      wait_idle();
   endtask

   // long output hold while requests keep coming, so the row freezes
   task automatic test_output_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      load_registers(PENALTY_RESET, MIN_AGE_RESET, FULL_COUNT_RESET);
      hold_asked++;
      random_burst(30);
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (victim_q.size() == 0) begin
            report_mismatch("result transfer with none pending", '0,
                            32'({rsp_tuser, rsp_tdata}));
         end else begin
            seen_victim = victim_q.pop_front();
            if (rsp_tuser !== seen_victim.found)
               report_mismatch("found", 32'(seen_victim.found), 32'(rsp_tuser));
            if (rsp_tdata !== {{(RSP_DATA_BITS-SLOT_BITS){1'b0}}, seen_victim.index})
               report_mismatch("victim_index", 32'(seen_victim.index), 32'(rsp_tdata));
         end
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) owner_pool[i] = OWNER_ID_BITS'($urandom);
      time_base = 32'hFFFF_0000 | $urandom_range(0, 65535);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_extremes();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_output_backpressure();
      $display("covered %0d writes, %0d clears, %0d queries (%0d with a victim)",
               n_writes, n_clears, n_queries, n_found);
      $display("over %0d register settings, with input gaps, output stalls and a long hold",
               n_settings);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timed out with %0d results pending", victim_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- idle_entry_victim_select_unit.f -----
+incdir+hw/rtl
hw/rtl/ievs_pkg.sv
hw/rtl/ievs_cell.sv
hw/rtl/idle_entry_victim_select_unit.sv
tb/idle_entry_victim_select_unit_tb.sv
